FILE: src/hec_pkg.sv
// Shared types, constants and a helper function for the Hamming encoder and corrector.
package hec_pkg;

   // Field widths fixed by the interface.
   localparam int WORD_W      = 63;
   localparam int DATA_BITS_W = 6;
   localparam int SYN_W       = 6;
   localparam int CHK_W       = 3;
   localparam int CHECK_MAX   = 6;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;

   // Defaults for the top-level parameter and the register reset values.
   localparam int                     DEFAULT_MAX_DATA_BITS = 57;
   localparam logic [DATA_BITS_W-1:0] DATA_BITS_RESET       = 6'd4;
   localparam logic                   ODD_PARITY_RESET      = 1'b0;

   // Operation codes.
   localparam logic OP_ENCODE = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   // Register indexes, taken from address bit 2.
   localparam logic REG_DATA_BITS  = 1'b0;
   localparam logic REG_ODD_PARITY = 1'b1;

   // One input beat.
   typedef struct packed {
      logic              opcode;
      logic [WORD_W-1:0] word;
   } req_type;

   // One result beat.
   typedef struct packed {
      logic [WORD_W-1:0] codeword;
      logic              error_found;
      logic [SYN_W-1:0]  syndrome;
      logic              syndrome_beyond;
   } rsp_type;

   // Code shape derived from the configuration registers.
   typedef struct packed {
      logic [WORD_W-1:0]      data_mask;
      logic [WORD_W-1:0]      code_mask;
      logic [DATA_BITS_W-1:0] code_len;
      logic                   odd;
   } cfg_type;

   // Least r with 2^r >= m + r + 1, for m from 1 to 57.
   function automatic logic [CHK_W-1:0] check_count(input logic [DATA_BITS_W-1:0] m);
      logic [CHK_W-1:0] r;
      if (m <= 6'd1) begin
         r = 3'd2;
      end else if (m <= 6'd4) begin
         r = 3'd3;
      end else if (m <= 6'd11) begin
         r = 3'd4;
      end else if (m <= 6'd26) begin
         r = 3'd5;
      end else begin
         r = 3'd6;
      end
      return r;
   endfunction

endpackage

FILE: src/hec_csr.sv
// Configuration registers and the code shape derived from them.
module hec_csr #(
   parameter int MAX_DATA_BITS = hec_pkg::DEFAULT_MAX_DATA_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [hec_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [hec_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [hec_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready,
   output hec_pkg::cfg_type                cfg
);
   import hec_pkg::*;

   logic [DATA_BITS_W-1:0] data_bits_ff;
   logic [DATA_BITS_W-1:0] data_bits_in;
   logic                   odd_parity_ff;
   logic                   odd_parity_in;
   logic                   wr_en;
   logic                   reg_sel;
   logic [DATA_BITS_W-1:0] m_used;
   logic [DATA_BITS_W-1:0] n_used;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = paddr[2];

   // Register write decode.
   always_comb begin
      data_bits_in  = data_bits_ff;
      odd_parity_in = odd_parity_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_DATA_BITS:  data_bits_in  = pwdata[DATA_BITS_W-1:0];
            REG_ODD_PARITY: odd_parity_in = pwdata[0];
            default: begin
               data_bits_in  = data_bits_ff;
               odd_parity_in = odd_parity_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_bits_ff  <= DATA_BITS_RESET;
         odd_parity_ff <= ODD_PARITY_RESET;
      end else begin
         data_bits_ff  <= data_bits_in;
         odd_parity_ff <= odd_parity_in;
      end
   end

   // Read mux.
   always_comb begin
      case (reg_sel)
         REG_DATA_BITS:  prdata = {{(CSR_DATA_W-DATA_BITS_W){1'b0}}, data_bits_ff};
         REG_ODD_PARITY: prdata = {{(CSR_DATA_W-1){1'b0}}, odd_parity_ff};
         default:        prdata = '0;
      endcase
   end

   // A data length of zero acts as one, and anything above the maximum acts as the maximum.
   always_comb begin
      if (data_bits_ff == '0) begin
         m_used = 6'd1;
      end else if (data_bits_ff > DATA_BITS_W'(MAX_DATA_BITS)) begin
         m_used = DATA_BITS_W'(MAX_DATA_BITS);
      end else begin
         m_used = data_bits_ff;
      end
      n_used = m_used + DATA_BITS_W'(check_count(m_used));
   end

   // Masks of the data bits in use and of the codeword positions in use.
   always_comb begin
      for (int i = 0; i < WORD_W; i++) begin
         cfg.data_mask[i] = DATA_BITS_W'(i) < m_used;
         cfg.code_mask[i] = DATA_BITS_W'(i) < n_used;
      end
      cfg.code_len = n_used;
      cfg.odd      = odd_parity_ff;
   end

endmodule

FILE: src/hec_scatter.sv
// First stage: places data bits into the non-power positions, or masks a received word.
module hec_scatter (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  hec_pkg::req_type           in_req,
   input  hec_pkg::cfg_type           cfg,
   output logic                       out_valid,
   output logic                       out_opcode,
   output logic [hec_pkg::WORD_W-1:0] out_word,
   output logic [hec_pkg::DATA_BITS_W-1:0] out_code_len,
   output logic                       out_odd
);
   import hec_pkg::*;

   logic                   valid_ff;
   logic                   opcode_ff;
   logic [WORD_W-1:0]      word_ff;
   logic [WORD_W-1:0]      word_in;
   logic [DATA_BITS_W-1:0] code_len_ff;
   logic                   odd_ff;
   logic [WORD_W-1:0]      data_used;
   logic [WORD_W-1:0]      spread;

   // The k-th data bit always lands on the k-th non-power position, whatever the length.
   always_comb begin
      int k;
      k         = 0;
      spread    = '0;
      data_used = in_req.word & cfg.data_mask;
      for (int pos = 1; pos <= WORD_W; pos++) begin
         if ((pos & (pos - 1)) != 0) begin
            spread[pos-1] = data_used[k];
            k = k + 1;
         end
      end
   end

   assign word_in = (in_req.opcode == OP_ENCODE) ? spread : (in_req.word & cfg.code_mask);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   // Payload travels with its own copy of the code shape.
   always_ff @(posedge clock) begin
      if (in_valid) begin
         opcode_ff   <= in_req.opcode;
         word_ff     <= word_in;
         code_len_ff <= cfg.code_len;
         odd_ff      <= cfg.odd;
      end
   end

   assign out_valid    = valid_ff;
   assign out_opcode   = opcode_ff;
   assign out_word     = word_ff;
   assign out_code_len = code_len_ff;
   assign out_odd      = odd_ff;

endmodule

FILE: src/hec_parity.sv
// Second stage: XOR trees over each parity group of the codeword.
module hec_parity (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic                            in_opcode,
   input  logic [hec_pkg::WORD_W-1:0]      in_word,
   input  logic [hec_pkg::DATA_BITS_W-1:0] in_code_len,
   input  logic                            in_odd,
   output logic                            out_valid,
   output logic                            out_opcode,
   output logic [hec_pkg::WORD_W-1:0]      out_word,
   output logic [hec_pkg::DATA_BITS_W-1:0] out_code_len,
   output logic [hec_pkg::SYN_W-1:0]       out_parity
);
   import hec_pkg::*;

   logic                   valid_ff;
   logic                   opcode_ff;
   logic [WORD_W-1:0]      word_ff;
   logic [DATA_BITS_W-1:0] code_len_ff;
   logic [SYN_W-1:0]       parity_ff;
   logic [SYN_W-1:0]       parity_in;
   logic [SYN_W-1:0]       group_x;

   // Group p covers positions whose index has bit p set; only groups whose check
   // position lies inside the codeword count.
   always_comb begin
      for (int p = 0; p < CHECK_MAX; p++) begin
         group_x[p] = 1'b0;
         for (int i = 0; i < WORD_W; i++) begin
            if ((((i + 1) >> p) & 1) != 0) begin
               group_x[p] = group_x[p] ^ in_word[i];
            end
         end
         parity_in[p] = ((7'd1 << p) <= {1'b0, in_code_len}) ? (group_x[p] ^ in_odd) : 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         opcode_ff   <= in_opcode;
         word_ff     <= in_word;
         code_len_ff <= in_code_len;
         parity_ff   <= parity_in;
      end
   end

   assign out_valid    = valid_ff;
   assign out_opcode   = opcode_ff;
   assign out_word     = word_ff;
   assign out_code_len = code_len_ff;
   assign out_parity   = parity_ff;

endmodule

FILE: src/hec_correct.sv
// Third stage: inserts check bits on encode, or flips the named bit on decode.
module hec_correct (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic                            in_opcode,
   input  logic [hec_pkg::WORD_W-1:0]      in_word,
   input  logic [hec_pkg::DATA_BITS_W-1:0] in_code_len,
   input  logic [hec_pkg::SYN_W-1:0]       in_parity,
   output logic                            rsp_strobe,
   output hec_pkg::rsp_type                rsp_payload
);
   import hec_pkg::*;

   logic              strobe_ff;
   rsp_type           rsp_ff;
   rsp_type           rsp_in;
   logic [WORD_W-1:0] check_bits;
   logic [WORD_W-1:0] flip;
   logic              nonzero;
   logic              beyond;

   // Check bit p sits at position 2^p.
   always_comb begin
      check_bits = '0;
      for (int p = 0; p < CHECK_MAX; p++) begin
         check_bits[(1 << p) - 1] = in_parity[p];
      end
   end

   // A nonzero syndrome inside the codeword names the bit to flip.
   assign nonzero = in_parity != '0;
   assign beyond  = nonzero && (in_parity > in_code_len);
   assign flip    = (nonzero && !beyond) ?
                    (WORD_W'(1) << (in_parity - SYN_W'(1))) : '0;

   always_comb begin
      if (in_opcode == OP_ENCODE) begin
         rsp_in.codeword        = in_word | check_bits;
         rsp_in.error_found     = 1'b0;
         rsp_in.syndrome        = '0;
         rsp_in.syndrome_beyond = 1'b0;
      end else begin
         rsp_in.codeword        = in_word ^ flip;
         rsp_in.error_found     = nonzero;
         rsp_in.syndrome        = in_parity;
         rsp_in.syndrome_beyond = beyond;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: src/hamming_encode_correct.sv
// Top level of the pipelined Hamming single-error encoder and corrector.
//
// Usage: a beat is taken on start at any rising edge; busy stays low, so the
// block accepts one beat in every cycle. Each beat carries an opcode (encode
// or check-and-correct) and a 63-bit word. Every beat gives exactly one
// result beat, shown on rsp_payload for one cycle with rsp_strobe high.
// Pipeline: three register stages (scatter, parity trees, correction), each
// taking a new word every cycle; throughput is one beat per cycle.
// The data length and the parity sense are written through the APB port;
// the user must write them only while the pipeline is empty, which the
// block itself does not enforce. Each beat carries the code shape it
// entered with. Reset empties the pipeline and restores a length of four
// data bits with even parity. The receiver cannot stall, so no result is
// ever held back: the downstream side must take every strobed beat.
module hamming_encode_correct #(
   parameter int MAX_DATA_BITS = hec_pkg::DEFAULT_MAX_DATA_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  hec_pkg::req_type               req_payload,
   output logic                           rsp_strobe,
   output hec_pkg::rsp_type               rsp_payload,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [hec_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [hec_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [hec_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import hec_pkg::*;

   cfg_type                cfg;
   logic                   accept;
   logic                   s1_valid;
   logic                   s1_opcode;
   logic [WORD_W-1:0]      s1_word;
   logic [DATA_BITS_W-1:0] s1_code_len;
   logic                   s1_odd;
   logic                   s2_valid;
   logic                   s2_opcode;
   logic [WORD_W-1:0]      s2_word;
   logic [DATA_BITS_W-1:0] s2_code_len;
   logic [SYN_W-1:0]       s2_parity;

   // The pipeline never stalls.
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   hec_csr #(
      .MAX_DATA_BITS(MAX_DATA_BITS)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   hec_scatter u_scatter (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (accept),
      .in_req       (req_payload),
      .cfg          (cfg),
      .out_valid    (s1_valid),
      .out_opcode   (s1_opcode),
      .out_word     (s1_word),
      .out_code_len (s1_code_len),
      .out_odd      (s1_odd)
   );

   hec_parity u_parity (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (s1_valid),
      .in_opcode    (s1_opcode),
      .in_word      (s1_word),
      .in_code_len  (s1_code_len),
      .in_odd       (s1_odd),
      .out_valid    (s2_valid),
      .out_opcode   (s2_opcode),
      .out_word     (s2_word),
      .out_code_len (s2_code_len),
      .out_parity   (s2_parity)
   );

   hec_correct u_correct (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s2_valid),
      .in_opcode   (s2_opcode),
      .in_word     (s2_word),
      .in_code_len (s2_code_len),
      .in_parity   (s2_parity),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   // Every accepted beat comes out as a result strobe after the scatter, parity and correction registers.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##3 rsp_strobe)
      else $error("accepted beat did not produce a result three cycles later");

   // A result strobe always traces back to a beat held in the parity stage.
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(s2_valid))
      else $error("result strobe without a beat in the parity stage");

   // The error flag agrees with the reported syndrome.
   a_err_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_payload.error_found == (rsp_payload.syndrome != '0)))
      else $error("error flag disagrees with syndrome");

   // An out-of-range syndrome is always also an error.
   a_beyond: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_payload.syndrome_beyond |-> rsp_payload.error_found)
      else $error("syndrome beyond codeword without error flag");

endmodule

FILE: tb/hec_result_check.sv
// Checker for the Hamming encoder and corrector: predicts and compares every result beat.
`timescale 1ns / 1ps

module hec_result_check
   import hec_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  req_type               req_payload,
   input  logic                  rsp_strobe,
   input  rsp_type               rsp_payload,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   input  logic [CSR_DATA_W-1:0] prdata,
   output int                    fail_count,
   output int                    pending
);

   // Results still owed by the block, oldest first.
   rsp_type codes_due[$];

   // Shadow copy of the two registers.
   logic [DATA_BITS_W-1:0] shadow_data_bits;
   logic                   shadow_odd;
   int                     errors = 0;

   // Print one mismatch line and count it.
   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      errors++;
   endtask

   // Expected result of one beat under the given code shape.
   function automatic rsp_type hamming_result(input logic op, input logic [WORD_W-1:0] w,
                                              input logic [DATA_BITS_W-1:0] dbits,
                                              input logic odd);
      rsp_type          res;
      logic [WORD_W-1:0] cw;
      logic [63:0]      nmask;
      logic [SYN_W-1:0] syn;
      logic             par;
      int               m;
      int               r;
      int               n;
      int               k;
      int               pos;
      int               p;
      // Out-of-range lengths are clamped to the supported span.
      m = int'(dbits);
      if (m < 1) m = 1;
      if (m > DEFAULT_MAX_DATA_BITS) m = DEFAULT_MAX_DATA_BITS;
      r = 0;
      while ((1 << r) < m + r + 1) r++;
      n = m + r;
      nmask = (64'd1 << n) - 64'd1;
      cw = '0;
      syn = '0;
      res = '0;
      if (op == OP_ENCODE) begin
         // Scatter data bits into the positions that are not powers of two.
         k = 0;
         for (pos = 1; pos <= n; pos++) begin
            if ((pos & (pos - 1)) != 0) begin
               cw[pos-1] = w[k];
               k++;
            end
         end
         // Each check bit brings its group to the selected parity.
         for (p = 0; (1 << p) <= n; p++) begin
            par = odd;
            for (pos = 1; pos <= n; pos++) begin
               if (((pos >> p) & 1) != 0) par ^= cw[pos-1];
            end
            cw[(1 << p) - 1] = par;
         end
      end else begin
         // Recompute each group; the failing groups spell out the syndrome.
         cw = w & nmask[WORD_W-1:0];
         for (p = 0; (1 << p) <= n; p++) begin
            par = odd;
            for (pos = 1; pos <= n; pos++) begin
               if (((pos >> p) & 1) != 0) par ^= cw[pos-1];
            end
            syn[p] = par;
         end
         if (syn != '0) begin
            res.error_found = 1'b1;
            if (int'(syn) <= n) begin
               cw[int'(syn) - 1] = ~cw[int'(syn) - 1];
            end else begin
               res.syndrome_beyond = 1'b1;
            end
         end
      end
      res.codeword = cw & nmask[WORD_W-1:0];
      res.syndrome = syn;
      return res;
   endfunction

   // Track register writes, check reads, queue predictions and compare results.
   always @(posedge clock) begin
      rsp_type want;
      logic [CSR_DATA_W-1:0] reg_value;
      if (reset) begin
         codes_due.delete();
         shadow_data_bits = DATA_BITS_RESET;
         shadow_odd = ODD_PARITY_RESET;
      end else begin
         if (psel && penable && pready) begin
            if (pwrite) begin
               if (paddr[2] == REG_DATA_BITS) begin
                  shadow_data_bits = pwdata[DATA_BITS_W-1:0];
               end else begin
                  shadow_odd = pwdata[0];
               end
            end else begin
               reg_value = '0;
               if (paddr[2] == REG_DATA_BITS) begin
                  reg_value[DATA_BITS_W-1:0] = shadow_data_bits;
               end else begin
                  reg_value[0] = shadow_odd;
               end
               if (prdata !== reg_value) report("register read", 64'(prdata), 64'(reg_value));
            end
         end
         if (start && !busy) begin
            codes_due.push_back(hamming_result(req_payload.opcode, req_payload.word,
                                               shadow_data_bits, shadow_odd));
         end
         if (rsp_strobe) begin
            if (codes_due.size() == 0) begin
               report("result beat with nothing expected", 64'(rsp_payload.codeword), 64'd0);
            end else begin
               want = codes_due.pop_front();
               if (rsp_payload.codeword !== want.codeword)
                  report("codeword", 64'(rsp_payload.codeword), 64'(want.codeword));
               if (rsp_payload.error_found !== want.error_found)
                  report("error_found", 64'(rsp_payload.error_found), 64'(want.error_found));
               if (rsp_payload.syndrome !== want.syndrome)
                  report("syndrome", 64'(rsp_payload.syndrome), 64'(want.syndrome));
               if (rsp_payload.syndrome_beyond !== want.syndrome_beyond)
                  report("syndrome_beyond", 64'(rsp_payload.syndrome_beyond),
                         64'(want.syndrome_beyond));
            end
         end
      end
      pending <= codes_due.size();
      fail_count <= errors;
   end

endmodule

FILE: tb/tb_hamming_encode_correct.sv
// Top of the Hamming encoder and corrector testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_hamming_encode_correct;
   import hec_pkg::*;

   localparam int CYCLE_LIMIT = 100000;
   localparam int BEATS_PER_PHASE = 80;
   localparam int PHASES = 10;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_type               req_payload;
   logic                  rsp_strobe;
   rsp_type               rsp_payload;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   int                    fail_count;
   int                    pending;
   int                    cycles = 0;

   hamming_encode_correct DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   hec_result_check u_check (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .pready      (pready),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_hamming_encode_correct NOT OK");
         $finish;
      end
   end

   // Present one beat and hold it until the block takes it.
   task automatic send_beat(input logic op, input logic [WORD_W-1:0] w);
      start <= 1'b1;
      req_payload <= '{opcode: op, word: w};
      do @(posedge clock); while (busy);
   endtask

   // Random 63-bit word.
   function automatic logic [WORD_W-1:0] any_word();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[WORD_W-1:0];
   endfunction

   // Wait until every predicted result has come back.
   task automatic wait_drained();
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // One register access: setup cycle, then access until ready.
   task automatic csr_access(input logic wr, input logic idx, input logic [CSR_DATA_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Set both registers while idle and read them back.
   task automatic set_code(input logic [DATA_BITS_W-1:0] dbits, input logic odd);
      start <= 1'b0;
      wait_drained();
      csr_access(1'b1, REG_DATA_BITS, {26'd0, dbits});
      csr_access(1'b1, REG_ODD_PARITY, {31'd0, odd});
      csr_access(1'b0, REG_DATA_BITS, '0);
      csr_access(1'b0, REG_ODD_PARITY, '0);
   endtask

   logic [DATA_BITS_W-1:0] phase_lengths[PHASES] = '{6'd3, 6'd1, 6'd57, 6'd0, 6'd63,
                                                     6'd2, 6'd11, 6'd12, 6'd26, 6'd27};

   initial begin
      int pct;
      int i;
      int ph;
      reset <= 1'b1;
      start <= 1'b0;
      req_payload <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default shape: four data bits, even parity.
      send_beat(OP_ENCODE, '0);
      send_beat(OP_ENCODE, '1);
      send_beat(OP_ENCODE, 63'h5);
      send_beat(OP_DECODE, '0);
      send_beat(OP_DECODE, '1);
      // A clean all-zero codeword with one position flipped.
      for (i = 0; i < 7; i++) send_beat(OP_DECODE, 63'd1 << i);

      // Short code where the syndrome can point past the end, odd parity.
      set_code(6'd2, 1'b1);
      send_beat(OP_ENCODE, '0);
      send_beat(OP_ENCODE, '1);
      send_beat(OP_DECODE, '0);
      send_beat(OP_DECODE, '1);
      send_beat(OP_DECODE, 63'h7FFF_FFFF_FFFF_FFE0);

      // Longest code, even parity.
      set_code(6'd57, 1'b0);
      send_beat(OP_ENCODE, '1);
      send_beat(OP_ENCODE, '0);
      send_beat(OP_DECODE, '1);
      send_beat(OP_DECODE, '0);
      send_beat(OP_DECODE, 63'd1 << 62);
      send_beat(OP_DECODE, 63'd1 << 31);

      // Lengths outside the range are clamped.
      set_code(6'd0, 1'b1);
      send_beat(OP_ENCODE, 63'd1);
      send_beat(OP_DECODE, '0);
      set_code(6'd63, 1'b0);
      send_beat(OP_ENCODE, '1);

      // Random beats over a range of code shapes and idle patterns.
      for (ph = 0; ph < PHASES; ph++) begin
         set_code(phase_lengths[ph], 1'((ph + $urandom_range(1)) % 2));
         case (ph % 4)
            1: pct = 53;
            3: pct = 14;
            default: pct = 0;
         endcase
         for (i = 0; i < BEATS_PER_PHASE; i++) begin
            if (ph == 5 && i == BEATS_PER_PHASE / 2) begin
               // Let the pipeline empty completely before going on.
               start <= 1'b0;
               wait_drained();
            end else if (pct != 0 && $urandom_range(99) < pct) begin
               start <= 1'b0;
               do @(posedge clock); while ($urandom_range(99) < pct);
            end
            send_beat($urandom_range(1) ? OP_DECODE : OP_ENCODE, any_word());
         end
      end

      start <= 1'b0;
      wait_drained();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_hamming_encode_correct OK");
      end else begin
         $display("tb_hamming_encode_correct NOT OK");
      end
      $finish;
   end

endmodule
